// File: hdl/pll_fm_demodulator_assert.svh
// assertion macros shared by the checker module
`ifndef PLL_FM_DEMODULATOR_ASSERT_SVH
`define PLL_FM_DEMODULATOR_ASSERT_SVH

// implication checked every clock, disabled during reset
`define PFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication checked every clock, disabled during reset
`define PFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// File: hdl/pfd_pkg.sv
// package for the pll fm demodulator: widths, register indexes, cordic table
`default_nettype none
package pfd_pkg;
    localparam int CORDIC_STAGES = 24;
    localparam int PHASE_BITS    = 32;
    localparam int CW            = 40;   // cordic datapath width
    localparam int AW            = 46;   // accumulator width for freq values and q24 products
    localparam int STG_W         = 5;

    localparam logic [2:0] REG_BETA  = 3'd0;
    localparam logic [2:0] REG_ALPHA = 3'd1;
    localparam logic [2:0] REG_LIMIT = 3'd2;
    localparam logic [2:0] REG_DCA   = 3'd3;
    localparam logic [2:0] REG_GAIN  = 3'd4;

    typedef struct packed {
        logic [24:0] beta;
        logic [24:0] alpha;
        logic [31:0] limit;
        logic [24:0] dca;
        logic [31:0] gain;
    } t_cfg;

    function automatic logic [31:0] atan_tab(input logic [STG_W-1:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// File: hdl/pfd_cordic.sv
// iterative vectoring cordic: one micro-rotation per cycle, returns the angle
`default_nettype none
module pfd_cordic import pfd_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [15:0]   i_x,
    input  wire logic [15:0]   i_y,
    output logic               o_done,
    output logic [31:0]        o_angle
);
    logic signed [CW-1:0] r_x, r_y, n_x, n_y;
    logic [31:0] r_z, n_z;
    logic [STG_W-1:0] r_i, n_i;
    logic r_busy, n_busy, n_done;

    always_comb begin
        logic signed [CW-1:0] x0, y0, dx, dy;
        x0 = CW'(signed'(i_x)) <<< 14;
        y0 = CW'(signed'(i_y)) <<< 14;
        n_x = r_x; n_y = r_y; n_z = r_z; n_i = r_i; n_busy = r_busy; n_done = 1'b0;
        dx = r_y >>> r_i;
        dy = r_x >>> r_i;
        if (i_start) begin
            // quarter-turn pre-rotation into the right half plane
            if (x0 < 0) begin
                if (y0 >= 0) begin
                    n_x = y0; n_y = -x0; n_z = 32'h4000_0000;
                end else begin
                    n_x = -y0; n_y = x0; n_z = 32'hC000_0000;
                end
            end else begin
                n_x = x0; n_y = y0; n_z = '0;
            end
            n_i = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_y > 0) begin
                n_x = r_x + dx; n_y = r_y - dy; n_z = r_z + atan_tab(r_i);
            end else begin
                n_x = r_x - dx; n_y = r_y + dy; n_z = r_z - atan_tab(r_i);
            end
            n_i = r_i + 1'b1;
            if (r_i == STG_W'(CORDIC_STAGES - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_y <= n_y; r_z <= n_z; r_i <= n_i;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            o_done <= n_done;
        end
    end

    assign o_angle = r_z;
endmodule
`default_nettype wire

// File: hdl/pfd_loop.sv
// loop filter sequencer: one shared q24 multiplier, clamps and audio scaling
`default_nettype none
module pfd_loop import pfd_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [31:0]   i_err,
    input  wire t_cfg          i_cfg,
    output logic               o_done,
    output logic [31:0]        o_audio,
    output logic [31:0]        o_phase
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAG   = 3'd1;
    localparam logic [2:0] S_LO    = 3'd2;
    localparam logic [2:0] S_HI    = 3'd3;
    localparam logic [2:0] S_APPLY = 3'd4;
    localparam logic [2:0] S_DIFF  = 3'd5;

    // which product the multiplier is working on
    localparam logic [1:0] OP_BETA  = 2'd0;
    localparam logic [1:0] OP_ALPHA = 2'd1;
    localparam logic [1:0] OP_DC    = 2'd2;
    localparam logic [1:0] OP_AUD   = 2'd3;

    logic [2:0] r_st;
    logic [1:0] r_sel;
    logic signed [AW-1:0] r_freq, r_avg, r_op, r_acc;
    logic [31:0] r_k, r_phase, r_audio;
    logic [35:0] r_mag;
    logic r_neg, r_done;
    logic [51:0] r_plo;      // mag * k[15:0]

    logic [15:0] khalf;
    logic [51:0] prod;
    logic [67:0] t;
    logic signed [AW-1:0] q, lim, dmax, f_sum, a_sum, diff;

    // product of magnitude and coefficient halves, one 36x16 multiply per cycle
    assign khalf = (r_st == S_LO) ? r_k[15:0] : r_k[31:16];
    assign prod  = r_mag * khalf;

    // rounded q24 result as signed
    assign t = ({16'd0, prod} << 16) + {16'd0, r_plo} + 68'h80_0000;
    assign q = r_neg ? -AW'(t[67:24]) : AW'(t[67:24]);

    assign lim   = AW'({1'b0, i_cfg.limit});
    assign dmax  = AW'(36'sh1_FFFF_FFFF);
    assign f_sum = r_freq + r_acc;
    assign a_sum = r_avg + r_acc;
    assign diff  = r_freq - r_avg;

    // sequencer: magnitude, low half, high half, then apply the product; a diff step sets up the audio product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_freq  <= '0;
            r_avg   <= '0;
            r_phase <= '0;
        end else begin
            unique case (r_st)
                S_IDLE: begin
                    if (i_start) begin
                        r_op  <= AW'(signed'(i_err));
                        r_k   <= {7'd0, i_cfg.beta};
                        r_sel <= OP_BETA;
                        r_st  <= S_MAG;
                    end
                end
                S_MAG: begin
                    r_neg <= r_op < 0;
                    r_mag <= (r_op < 0) ? 36'(-r_op) : 36'(r_op);
                    r_st  <= S_LO;
                end
                S_LO: begin
                    r_plo <= prod;
                    r_st  <= S_HI;
                end
                S_HI: begin
                    r_acc <= q;
                    r_st  <= S_APPLY;
                end
                S_APPLY: begin
                    unique case (r_sel)
                        OP_BETA: begin
                            if (f_sum > lim) r_freq <= lim;
                            else if (f_sum < -lim) r_freq <= -lim;
                            else r_freq <= f_sum;
                            r_k   <= {7'd0, i_cfg.alpha};
                            r_sel <= OP_ALPHA;
                            r_st  <= S_MAG;
                        end
                        OP_ALPHA: begin
                            r_phase <= r_phase + 32'(r_freq + r_acc);
                            r_op    <= diff;
                            r_k     <= {7'd0, i_cfg.dca};
                            r_sel   <= OP_DC;
                            r_st    <= S_MAG;
                        end
                        OP_DC: begin
                            if (a_sum > dmax) r_avg <= dmax;
                            else if (a_sum < -dmax) r_avg <= -dmax;
                            else r_avg <= a_sum;
                            r_sel <= OP_AUD;
                            r_st  <= S_DIFF;
                        end
                        OP_AUD: begin
                            if (r_acc > AW'(64'sd2147483647)) r_audio <= 32'h7FFF_FFFF;
                            else if (r_acc < -AW'(64'sd2147483648)) r_audio <= 32'h8000_0000;
                            else r_audio <= r_acc[31:0];
                            r_st <= S_IDLE;
                        end
                    endcase
                end
                // difference against the updated average feeds the audio gain
                S_DIFF: begin
                    r_op <= diff;
                    r_k  <= i_cfg.gain;
                    r_st <= S_MAG;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // one-cycle pulse once the audio sample is saturated
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else r_done <= (r_st == S_APPLY) && (r_sel == OP_AUD);
    end

    assign o_done  = r_done;
    assign o_audio = r_audio;
    assign o_phase = r_phase;
endmodule
`default_nettype wire

// File: hdl/pll_fm_demodulator.sv
// Second-order PLL FM demodulator top level.
// Input channel s_axis: tdata holds i_sample [15:0], q_sample [31:16];
// tlast carries block_last. Output channel m_axis: tdata holds the
// saturated 32-bit audio; tlast is the copy of block_last.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_data write one register per
// cycle: 0 beta, 1 alpha, 2 freq limit, 3 dc alpha, 4 audio gain.
// One item at a time: an item passes the 24 serial cordic micro-rotations
// with their start and pre-rotation, then the four q24 multiplies of the
// loop filter, each in magnitude, low half, high half and apply steps on
// one shared 36x16 multiplier. A zero input sample skips the cordic.
// s_axis_tready is low while an item is in work and drops in the cycle
// after the accept; it rises when the result moves into the output
// register, so no new item is taken before the last result is out.
// When the receiver stalls, a result waits in the output register and the
// next finished result waits in the loop until the register frees; the
// input stays blocked meanwhile.
// Reset (synchronous, active low) clears the NCO phase, frequency and DC
// average, restores the register defaults and empties the output register.
`default_nettype none
module pll_fm_demodulator import pfd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // i_sample [15:0], q_sample [31:16]
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // audio [31:0]
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);
    t_cfg r_cfg;
    logic r_busy, r_last, r_zero, r_loop_go, r_started, r_cstart, r_pend;
    logic [15:0] r_xi, r_xq;
    logic acc, cor_start, cor_done, loop_done, out_load;
    logic [31:0] ang, audio, phase, err, ph;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.beta  <= 25'd33554;
            r_cfg.alpha <= 25'd750316;
            r_cfg.limit <= 32'd3435973837;
            r_cfg.dca   <= 25'd1341436;
            r_cfg.gain  <= 32'd10485760;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BETA:  r_cfg.beta  <= i_cfg_data[24:0];
                REG_ALPHA: r_cfg.alpha <= i_cfg_data[24:0];
                REG_LIMIT: r_cfg.limit <= i_cfg_data;
                REG_DCA:   r_cfg.dca   <= i_cfg_data[24:0];
                REG_GAIN:  r_cfg.gain  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !r_busy;
    assign acc = s_axis_tvalid && s_axis_tready;
    // a finished result moves out when the output register is free or leaving
    assign out_load = (loop_done || r_pend) && (!m_axis_tvalid || m_axis_tready);

    // capture item
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_xi <= s_axis_tdata[15:0];
            r_xq <= s_axis_tdata[31:16];
            r_last <= s_axis_tlast;
            r_zero <= (s_axis_tdata == 32'd0);
        end
    end

    // item in work until its result reaches the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_busy <= 1'b0;
        else if (acc) r_busy <= 1'b1;
        else if (out_load) r_busy <= 1'b0;
    end

    // start the loop after the cordic, or directly for a zero sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_loop_go <= 1'b0;
        else r_loop_go <= cor_done || (r_busy && r_zero && !r_loop_go && !r_started);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_started <= 1'b0;
        else if (acc) r_started <= 1'b0;
        else if (r_loop_go) r_started <= 1'b1;
    end

    assign cor_start = r_busy && !r_zero && !r_started && !r_cstart;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || acc) r_cstart <= 1'b0;
        else if (cor_start) r_cstart <= 1'b1;
    end

    pfd_cordic u_cordic (
        .i_clk, .i_rst_n, .i_start(cor_start), .i_x(r_xi), .i_y(r_xq),
        .o_done(cor_done), .o_angle(ang)
    );

    // phase error = -(angle + phase - quarter turn)
    assign ph  = phase & ~((32'd1 << (32 - PHASE_BITS)) - 32'd1);
    assign err = r_zero ? 32'd0 : 32'd0 - (ang + ph - 32'h4000_0000);

    pfd_loop u_loop (
        .i_clk, .i_rst_n, .i_start(r_loop_go), .i_err(err), .i_cfg(r_cfg),
        .o_done(loop_done), .o_audio(audio), .o_phase(phase)
    );

    // finished result waiting for the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pend <= 1'b0;
        else if (out_load) r_pend <= 1'b0;
        else if (loop_done) r_pend <= 1'b1;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            m_axis_tdata <= audio;
            m_axis_tlast <= r_last;
        end
        if (!i_rst_n) m_axis_tvalid <= 1'b0;
        else if (out_load) m_axis_tvalid <= 1'b1;
        else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
endmodule
`default_nettype wire

// File: hdl/pfd_checker.sv
// port-level checker for the demodulator, bound to the top level
`default_nettype none
`include "pll_fm_demodulator_assert.svh"
module pfd_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic s_axis_tvalid,
    input wire logic s_axis_tready,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);
    logic in_acc, out_wait, out_free;
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_wait = m_axis_tvalid && !m_axis_tready;
    assign out_free = !m_axis_tvalid || m_axis_tready;

    // input closes right after an accepted item
    `PFD_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, !s_axis_tready)
    // a stalled result stays put
    `PFD_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, out_wait, m_axis_tvalid && $stable(m_axis_tdata))
    // no new result appears while the block is idle
    `PFD_ASSERT_NEXT(a_no_result_idle, i_clk, i_rst_n, out_free && s_axis_tready, !m_axis_tvalid)
    // a valid result carries known data
    `PFD_ASSERT_IMP(a_data_known, i_clk, i_rst_n, m_axis_tvalid, !$isunknown(m_axis_tdata))
endmodule
bind pll_fm_demodulator pfd_checker u_pfd_checker (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
    .m_axis_tdata
);
`default_nettype wire

// File: bench/pll_fm_demodulator_tb.sv
// testbench for the pll fm demodulator: random and directed i/q items checked against a predictor
module pll_fm_demodulator_tb;
    import pfd_pkg::*;

    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          SETTLE      = 60;     // longer than an item takes to pass through
    localparam logic [2:0]  REG_SPARE   = 3'd7;   // no register behind this index
    localparam bit   [31:0] QUARTER     = 32'h4000_0000;
    localparam bit   [31:0] ATAN_TURN [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1, 1, 0
    };

    // loop state, gains and the queue of audio samples still to come
    class fm_audio_scoreboard;
        bit [31:0] beta, alpha, limit, dca, gain;
        bit [31:0] phase;
        longint    freq, dc_avg;
        bit [32:0] audio_q[$];   // {last, audio}
        int        errors;

        function void clear();
            beta = 33554; alpha = 750316; limit = 32'd3435973837;
            dca = 1341436; gain = 10485760;
            phase = 0; freq = 0; dc_avg = 0;
            audio_q.delete();
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, bit [31:0] val);
            case (idx)
                REG_BETA:  beta  = val & 32'h1FF_FFFF;
                REG_ALPHA: alpha = val & 32'h1FF_FFFF;
                REG_LIMIT: limit = val;
                REG_DCA:   dca   = val & 32'h1FF_FFFF;
                REG_GAIN:  gain  = val;
                default: ;
            endcase
        endfunction

        // product with a q24 coefficient, rounded half away from zero
        function longint scale_q24(longint v, bit [31:0] k);
            bit                neg;
            longint unsigned   mag, lo, hi, q;
            neg = v < 0;
            mag = neg ? -v : v;
            lo  = mag * k[15:0];
            hi  = mag * k[31:16];
            q   = (hi + ((lo + 64'h80_0000) >> 16)) >> 8;
            return neg ? -longint'(q) : longint'(q);
        endfunction

        // vectoring cordic, angle of (x, y) in turns/2^32
        function bit [31:0] vector_angle(longint x, longint y);
            bit [31:0] z;
            longint    t, dx, dy;
            z = 0;
            if (x < 0) begin
                if (y >= 0) begin
                    t = x; x = y; y = -t; z = QUARTER;
                end else begin
                    t = x; x = -y; y = t; z = 32'hC000_0000;
                end
            end
            for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0) begin
                    x += dx; y -= dy; z += ATAN_TURN[i];
                end else begin
                    x -= dx; y += dy; z -= ATAN_TURN[i];
                end
            end
            return z;
        endfunction

        // advance the loop by one accepted item and queue its audio
        function void note_sample(bit signed [15:0] si, bit signed [15:0] sq, bit last);
            longint    err, lim, dmax, aud;
            bit [31:0] ph, e;
            lim  = longint'(limit);
            dmax = (64'sd1 <<< 33) - 1;
            err  = 0;
            ph   = phase & (32'hFFFF_FFFF << (32 - PHASE_BITS));
            if (si != 0 || sq != 0) begin
                e   = 32'd0 - (vector_angle(longint'(si) * 16384, longint'(sq) * 16384)
                               + ph - QUARTER);
                err = longint'(signed'(e));
            end
            freq += scale_q24(err, beta);
            if (freq > lim) freq = lim;
            else if (freq < -lim) freq = -lim;
            phase += 32'(freq + scale_q24(err, alpha));
            dc_avg += scale_q24(freq - dc_avg, dca);
            if (dc_avg > dmax) dc_avg = dmax;
            else if (dc_avg < -dmax) dc_avg = -dmax;
            aud = scale_q24(freq - dc_avg, gain);
            if (aud > 64'sd2147483647) aud = 64'sd2147483647;
            else if (aud < -64'sd2147483648) aud = -64'sd2147483648;
            audio_q.push_back({last, 32'(aud)});
        endfunction

        function void check_audio(bit [31:0] audio, bit last);
            bit [32:0] exp_item;
            if (audio_q.size() == 0) begin
                $error("unexpected audio item %h", audio);
                errors++;
                return;
            end
            exp_item = audio_q.pop_front();
            if (audio !== exp_item[31:0]) begin
                $error("audio: expected %h actual %h", exp_item[31:0], audio);
                errors++;
            end
            if (last !== exp_item[32]) begin
                $error("audio_last: expected %0d actual %0d", exp_item[32], last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 0;
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_idx = 0;
    logic [31:0] i_cfg_data = 0;

    fm_audio_scoreboard sb = new();
    bit  idle_on = 1;
    int  hold_req = 0;
    int  cycles = 0;

    pll_fm_demodulator u_top (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("pll_fm_demodulator test failed");
            $finish;
        end
    end

    // result side: random stalls, one long hold on request
    initial begin
        wait (i_rst_n);
        forever begin
            int stall;
            @(negedge i_clk);
            if (hold_req > 0) begin
                m_axis_tready = 0;
                repeat (hold_req) @(negedge i_clk);
                hold_req = 0;
            end
            stall = idle_on ? $urandom_range(0, 9) : 0;
            if (stall > 0) begin
                m_axis_tready = 0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_audio(m_axis_tdata, m_axis_tlast);
        end
    end

    // register write, called at a falling edge
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_we = 1; i_cfg_idx = idx; i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 0;
        sb.write_reg(idx, val);
    endtask

    // offer one item and wait for its acceptance
    task automatic send_sample(input logic [15:0] si, input logic [15:0] sq,
                               input logic last);
        int gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_axis_tvalid = 0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1;
        s_axis_tdata  = {sq, si};
        s_axis_tlast  = last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(si, sq, last);
        @(negedge i_clk);
    endtask

    // pause until every audio item is back and the block has settled
    task automatic drain();
        s_axis_tvalid = 0;
        while (sb.audio_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_level();
        logic signed [15:0] v;
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = 16'sh8000;
            2: v = 16'sh7FFF;
            3: v = $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
            default: v = 16'($urandom) >>> $urandom_range(0, 14);
        endcase
        return v;
    endfunction

    // random stretch with block marks, idling switched on and off
    task automatic random_run(input int n);
        for (int k = 0; k < n; k++) begin
            if (k % 50 == 0) idle_on = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 4) == 0 && (rand_level() & 1))
                send_sample(0, 0, $urandom_range(0, 7) == 0);
            else
                send_sample(rand_level(), rand_level(), $urandom_range(0, 7) == 0);
        end
        idle_on = 1;
    endtask

    initial begin
        logic [15:0] edge_vals [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF};
        sb.clear();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // defaults: extremes of i and q, zero input, block ends
        foreach (edge_vals[a])
            foreach (edge_vals[b])
                send_sample(edge_vals[a], edge_vals[b], (a + b) % 3 == 0);
        random_run(300);
        drain();

        // all gains at their top, widest limit, ignored index
        write_reg(REG_BETA, 32'h1FF_FFFF);
        write_reg(REG_ALPHA, 32'h1FF_FFFF);
        write_reg(REG_LIMIT, 32'hFFFF_FFFF);
        write_reg(REG_DCA, 32'h1FF_FFFF);
        write_reg(REG_GAIN, 32'hFFFF_FFFF);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        hold_req = 300;   // result side holds off while items keep coming
        random_run(350);
        drain();

        // everything at zero
        write_reg(REG_BETA, 0);
        write_reg(REG_ALPHA, 0);
        write_reg(REG_LIMIT, 0);
        write_reg(REG_DCA, 0);
        write_reg(REG_GAIN, 0);
        random_run(300);
        drain();

        // random settings, unit beta and alpha in the first pass
        for (int p = 0; p < 3; p++) begin
            write_reg(REG_BETA, p == 0 ? 32'h100_0000 : $urandom_range(0, 32'h40_0000));
            write_reg(REG_ALPHA, p == 0 ? 32'h100_0000 : $urandom_range(0, 32'h100_0000));
            write_reg(REG_LIMIT, $urandom);
            write_reg(REG_DCA, $urandom_range(0, 32'h1FF_FFFF));
            write_reg(REG_GAIN, $urandom);
            random_run(300);
            drain();
        end

        if (sb.errors == 0 && sb.audio_q.size() == 0)
            $display("pll_fm_demodulator test passed");
        else
            $display("pll_fm_demodulator test failed");
        $finish;
    end
endmodule

// File: files.f
+incdir+hdl
hdl/pfd_pkg.sv
hdl/pfd_cordic.sv
hdl/pfd_loop.sv
hdl/pll_fm_demodulator.sv
hdl/pfd_checker.sv
bench/pll_fm_demodulator_tb.sv
